>>> hw/rtl/sle_pkg.sv
// Shared types, codes and constants for the serial line editor.
`timescale 1ns / 1ps
package sle_pkg;

  localparam int SLE_BUFFER_SIZE = 32;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic PORT_SEND = 1'b0;
  localparam logic PORT_ECHO = 1'b1;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  localparam logic SEQ_ERASE = 1'b0;
  localparam logic SEQ_FLUSH = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic       port;
    logic [7:0] data;
    logic       last;
  } res_t;

  // Fixed output sequences: erase echo (BS SP BS) and line terminator (CR LF sent, CR LF echoed).
  function automatic res_t seq_entry(input logic kind, input logic [1:0] step);
    res_t r;
    r = '{port: PORT_ECHO, data: CH_BS, last: 1'b1};
    if (kind == SEQ_ERASE) begin
      case (step)
        2'd0: r = '{port: PORT_ECHO, data: CH_BS,    last: 1'b0};
        2'd1: r = '{port: PORT_ECHO, data: CH_SPACE, last: 1'b0};
        2'd2: r = '{port: PORT_ECHO, data: CH_BS,    last: 1'b1};
        default: r = '{port: PORT_ECHO, data: CH_BS, last: 1'b1};
      endcase
    end else begin
      case (step)
        2'd0: r = '{port: PORT_SEND, data: CH_CR, last: 1'b0};
        2'd1: r = '{port: PORT_SEND, data: CH_LF, last: 1'b0};
        2'd2: r = '{port: PORT_ECHO, data: CH_CR, last: 1'b0};
        2'd3: r = '{port: PORT_ECHO, data: CH_LF, last: 1'b1};
        default: r = '{port: PORT_ECHO, data: CH_LF, last: 1'b1};
      endcase
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/serial_line_editor_core.sv
// Top level of the serial line editor: front classifier and back executor.
`timescale 1ns / 1ps
// Received bytes are pushed in; results come out as a queue of {port, out_byte, last}, where
// port 0 carries a completed line and port 1 carries terminal echo. The input side buffers
// up to two bytes, so bytes are taken while the executor works. In the executor an ordinary
// byte yields one echo byte, a backspace or delete yields a three-byte erase echo, and a CR/LF
// on a line of n bytes yields the n held bytes and a four-byte terminator: each held byte
// passes a line-store read state and an emit state, and all results leave through a single
// output register, so a slow pop stalls the executor. The line store is a memory of BUFFER_SIZE-1 bytes.
module serial_line_editor_core
  import sle_pkg::*;
#(
  parameter int BUFFER_SIZE = SLE_BUFFER_SIZE
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic       port,
  output logic [7:0] out_byte,
  output logic       last
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  sle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  sle_back #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .port      (port),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

>>> hw/rtl/sle_front.sv
// Input side: classifies received bytes and queues commands for the executor.
`timescale 1ns / 1ps
module sle_front
  import sle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] rx_byte,
  output logic       full,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  cmd_t       queue [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  cmd_t       cls;

  always_comb begin
    cls.data = rx_byte;
    if (rx_byte == CH_CR || rx_byte == CH_LF) begin
      cls.kind = CMD_FLUSH;
    end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
      cls.kind = CMD_ERASE;
    end else begin
      cls.kind = CMD_APPEND;
    end
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, cmd_pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("command queue count overflow");

endmodule

>>> hw/rtl/sle_back.sv
// Executor: holds the line, emits echo and send bytes through one output register.
`timescale 1ns / 1ps
module sle_back
  import sle_pkg::*;
#(
  parameter int BUFFER_SIZE = SLE_BUFFER_SIZE
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       empty,
  input  logic       pop,
  output logic       port,
  output logic [7:0] out_byte,
  output logic       last
);

  localparam int MAX = BUFFER_SIZE - 1;
  localparam int AW  = (MAX > 1) ? $clog2(MAX) : 1;
  localparam int LW  = $clog2(BUFFER_SIZE);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SEQ     = 2'd1;
  localparam logic [1:0] S_FL_WAIT = 2'd2;
  localparam logic [1:0] S_FL_EMIT = 2'd3;

  logic [7:0]    line_mem [0:MAX-1];
  logic [7:0]    rd_data;

  logic [1:0]    state, state_next;
  logic [LW-1:0] len, len_next;
  logic [LW-1:0] idx, idx_next;
  logic [1:0]    step, step_next;
  logic          seq_kind, seq_kind_next;
  logic          out_valid;
  res_t          out_reg;

  logic          out_free;
  logic          load;
  res_t          ld;
  res_t          ent;
  logic          wr_en;

  assign out_free = !out_valid || pop;
  assign ent      = seq_entry(seq_kind, step);

  always_comb begin
    state_next    = state;
    len_next      = len;
    idx_next      = idx;
    step_next     = step;
    seq_kind_next = seq_kind;
    cmd_pop       = 1'b0;
    load          = 1'b0;
    wr_en         = 1'b0;
    ld            = '{port: PORT_ECHO, data: cmd.data, last: 1'b1};
    case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_APPEND: begin
              if (len < LW'(MAX)) begin
                wr_en    = 1'b1;
                len_next = len + 1'b1;
                load     = 1'b1;
              end
            end
            CMD_ERASE: begin
              if (len != '0) begin
                len_next      = len - 1'b1;
                state_next    = S_SEQ;
                seq_kind_next = SEQ_ERASE;
                step_next     = 2'd0;
              end
            end
            CMD_FLUSH: begin
              if (len != '0) begin
                idx_next   = '0;
                state_next = S_FL_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEQ: begin
        if (out_free) begin
          load      = 1'b1;
          ld        = ent;
          step_next = step + 2'd1;
          if (ent.last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_FL_WAIT: begin
        state_next = S_FL_EMIT;
      end
      S_FL_EMIT: begin
        if (out_free) begin
          load     = 1'b1;
          ld       = '{port: PORT_SEND, data: rd_data, last: 1'b0};
          idx_next = idx + 1'b1;
          if (LW'(idx + 1'b1) == len) begin
            state_next    = S_SEQ;
            seq_kind_next = SEQ_FLUSH;
            step_next     = 2'd0;
            len_next      = '0;
          end else begin
            state_next = S_FL_WAIT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[len[AW-1:0]] <= cmd.data;
    end
    rd_data <= line_mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= ld;
    end
    idx      <= idx_next;
    step     <= step_next;
    seq_kind <= seq_kind_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty    = !out_valid;
  assign port     = out_reg.port;
  assign out_byte = out_reg.data;
  assign last     = out_reg.last;

  a_len_bound: assert property (@(posedge clk) disable iff (rst) len <= LW'(MAX))
    else $error("line length above capacity");

  a_flush_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_FL_WAIT || state == S_FL_EMIT) |-> idx < len)
    else $error("flush index past line end");

  a_erase_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_pop && cmd.kind == CMD_ERASE && len != '0)
      |=> (len == $past(len) - 1'b1) && state == S_SEQ)
    else $error("erase did not shorten line");

  a_erase_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEQ && seq_kind == SEQ_ERASE) |-> step <= 2'd2)
    else $error("erase sequence overran");

endmodule

>>> dv/serial_line_editor_core_test.sv
// Self-checking testbench for the serial line editor: queue handshakes, line model, scoreboard.
`timescale 1ns / 1ps
module serial_line_editor_core_test
  import sle_pkg::*;
;

  localparam int LINE_MAX      = SLE_BUFFER_SIZE - 1;
  localparam int TOTAL_ITEMS   = 480;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 1000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] rx_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic       port;
  logic [7:0] out_byte;
  logic       last;

  logic [7:0] held_line [LINE_MAX];
  int         held_count = 0;
  res_t       expected_results [$];
  int         fail_count = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  int         sent_items = 0;
  int         pop_mode = 0;
  int         pop_mode_left = 0;
  int         pop_phase = 0;

  serial_line_editor_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .rx_byte  (rx_byte),
    .empty    (empty),
    .pop      (pop),
    .port     (port),
    .out_byte (out_byte),
    .last     (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    fail_count++;
  endtask

  function automatic void add_result(input logic p, input logic [7:0] d, input logic l);
    res_t r;
    r.port = p;
    r.data = d;
    r.last = l;
    expected_results.push_back(r);
  endfunction

  // Line editor model; returns the number of results the byte produces.
  function automatic int edit_line(input logic [7:0] ch);
    int n;
    n = 0;
    if (ch == CH_CR || ch == CH_LF) begin
      if (held_count != 0) begin
        for (int i = 0; i < held_count; i++) add_result(PORT_SEND, held_line[i], 1'b0);
        add_result(PORT_SEND, CH_CR, 1'b0);
        add_result(PORT_SEND, CH_LF, 1'b0);
        add_result(PORT_ECHO, CH_CR, 1'b0);
        add_result(PORT_ECHO, CH_LF, 1'b1);
        n = held_count + 4;
        held_count = 0;
      end
    end else if (ch == CH_BS || ch == CH_DEL) begin
      if (held_count != 0) begin
        add_result(PORT_ECHO, CH_BS, 1'b0);
        add_result(PORT_ECHO, CH_SPACE, 1'b0);
        add_result(PORT_ECHO, CH_BS, 1'b1);
        held_count--;
        n = 3;
      end
    end else if (held_count < LINE_MAX) begin
      held_line[held_count] = ch;
      held_count++;
      add_result(PORT_ECHO, ch, 1'b1);
      n = 1;
    end
    return n;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] control_byte();
    case ($urandom_range(0, 3))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_BS;
      default: return CH_DEL;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    int n;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    n = edit_line(b);
    sent_items++;
  endtask

  task automatic wait_for_drain();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Receiver: stall pattern changes mode whenever its randomly drawn mode length runs out.
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer, out_byte", out_byte, 0);
        end else begin
          want = expected_results.pop_front();
          if (port !== want.port) report_mismatch("port", port, want.port);
          if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
          if (last !== want.last) report_mismatch("last", last, want.last);
        end
      end
      if (pop_mode_left == 0) begin
        pop_mode      = $urandom_range(0, 3);
        pop_mode_left = $urandom_range(20, 200);
      end else begin
        pop_mode_left--;
      end
      pop_phase++;
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= (pop_phase % 7) < 3;
      endcase
    end
  end

  task automatic test_empty_line_controls();
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_BS);
    send_byte(CH_DEL);
  endtask

  task automatic test_byte_extremes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7E);
    send_byte(8'h09);
    send_byte(8'h0C);
    send_byte(CH_CR);
  endtask

  task automatic test_erase();
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(CH_BS);
    send_byte(CH_DEL);
    send_byte(CH_DEL);
    send_byte(8'h63);
    send_byte(CH_LF);
  endtask

  // Fill the line, overflow it, then flush the longest line.
  task automatic test_full_line();
    for (int i = 0; i < LINE_MAX + 2; i++) send_byte(text_byte());
    send_byte(CH_LF);
  endtask

  task automatic test_drain_pause();
    send_byte(8'h41);
    send_byte(8'h42);
    wait_for_drain();
    send_byte(CH_DEL);
    send_byte(CH_CR);
  endtask

  task automatic test_random_lines();
    int r;
    int len;
    while (sent_items < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        len = (r < 6) ? $urandom_range(25, 36) : $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 15) send_byte(($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL);
          else send_byte(text_byte());
        end
        send_byte(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(control_byte());
      end
      if ($urandom_range(0, 49) == 0) wait_for_drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_line_controls();
    test_byte_extremes();
    test_erase();
    test_full_line();
    test_drain_pause();
    test_random_lines();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results left over, count", expected_results.size(), 0);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_front.sv
hw/rtl/sle_back.sv
hw/rtl/serial_line_editor_core.sv
dv/serial_line_editor_core_test.sv
